@@ src/sa_pkg.sv @@
// sa_pkg: shared constants and types for the stable argsort unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sa_pkg;

    localparam int CAPACITY    = 64;
    localparam int KEY_BITS    = 32;
    localparam int IN_KEY_W    = 32;
    localparam int POS_W       = 6;
    // Only the low KEY_BITS of the key take part; the port carries 32.
    localparam int SKEY_W      = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [IN_KEY_W-1:0] key;
        logic                final_item;
    } in_data_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             final_result;
        logic             overflow;
    } out_data_t;

    // One stored element of the insertion chain.
    typedef struct packed {
        logic              valid;
        logic [SKEY_W-1:0] key;
        logic [POS_W-1:0]  pos;
    } entry_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic              ins;
        logic              shift;
        logic [SKEY_W-1:0] key;
        logic [POS_W-1:0]  pos;
    } cell_ctrl_t;

endpackage

@@ src/sa_cell.sv @@
// sa_cell: one slot of the sorted insertion chain.
// Depends on sa_pkg.
`timescale 1ns / 1ps

module sa_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  sa_pkg::entry_t     prev_i,
    input  sa_pkg::entry_t     next_i,
    input  logic               prev_gt_i,
    input  sa_pkg::cell_ctrl_t ctrl_i,
    output sa_pkg::entry_t     entry_o,
    output logic               gt_o
);
    import sa_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    entry_t new_entry;

    // Empty slots count as larger than any key.
    assign gt_o = !entry_reg.valid || (entry_reg.key > ctrl_i.key);

    always_comb begin
        new_entry.valid = 1'b1;
        new_entry.key   = ctrl_i.key;
        new_entry.pos   = ctrl_i.pos;
        entry_next      = entry_reg;
        priority if (ctrl_i.ins) begin
            if (prev_gt_i) begin
                entry_next = prev_i;      // make room: take left neighbor
            end else if (gt_o) begin
                entry_next = new_entry;   // first slot greater than the key
            end
        end else if (ctrl_i.shift) begin
            entry_next = next_i;          // drain toward slot 0
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry_o = entry_reg;

endmodule

@@ src/stable_argsort_unit.sv @@
// stable_argsort_unit: top level of the streaming stable argsort.
// Depends on sa_pkg and sa_cell.
`timescale 1ns / 1ps
//
// Load: one key per cycle; while a cell is free each key lands in its sorted
//   slot of the CAPACITY-cell chain as it is accepted (cells compare in parallel).
// Emit: after the final request, one position per cycle drains from cell 0
//   while the output register is free (m_ready stalls it); each shift loads
//   the output register. Input is held off (s_ready low) while a run drains.
// Reset (aresetn low, synchronous): clears cell valid bits, count, drop and
//   overflow flags, state and the output valid bit; no clearing pass.

module stable_argsort_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sa_pkg::in_data_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sa_pkg::out_data_t   m_data
);
    import sa_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic              drop_reg;
    logic              run_ovf_reg;
    logic              m_valid_reg;
    out_data_t         m_data_reg;

    cell_ctrl_t        ctrl;
    entry_t            entries [CAPACITY];
    logic              gts     [CAPACITY];

    logic              accept;
    logic              full;
    logic              out_free;
    logic              emit_load;
    logic              emit_last;

    assign s_ready  = (state_reg == ST_LOAD);
    assign accept   = s_valid && s_ready;
    assign full     = (fill_reg == CNT_W'(CAPACITY));
    assign out_free = !m_valid_reg || m_ready;

    // A run always holds at least one element when emission starts.
    assign emit_load = (state_reg == ST_EMIT) && out_free && entries[0].valid;
    assign emit_last = !entries[1].valid;

    always_comb begin
        ctrl.ins   = accept && !full;
        ctrl.shift = emit_load;
        ctrl.key   = s_data.key[SKEY_W-1:0];
        ctrl.pos   = POS_W'(fill_reg);   // arrival index, low bits only
    end

    // The cell chain: left neighbor feeds insertion, right neighbor feeds drain.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_gt;

        if (i == 0) begin : g_head
            assign prev_e  = '0;
            assign prev_gt = 1'b0;
        end else begin : g_body
            assign prev_e  = entries[i-1];
            assign prev_gt = gts[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign next_e = '0;
        end else begin : g_inner
            assign next_e = entries[i+1];
        end

        sa_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .prev_i    (prev_e),
            .next_i    (next_e),
            .prev_gt_i (prev_gt),
            .ctrl_i    (ctrl),
            .entry_o   (entries[i]),
            .gt_o      (gts[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            fill_reg    <= '0;
            drop_reg    <= 1'b0;
            run_ovf_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // New result loads the register; otherwise a taken one leaves it.
            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (accept) begin
                        if (full) begin
                            drop_reg <= 1'b1;
                        end else begin
                            fill_reg <= fill_reg + CNT_W'(1);
                        end
                        if (s_data.final_item) begin
                            run_ovf_reg <= drop_reg || full;
                            state_reg   <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        m_data_reg.position     <= entries[0].pos;
                        m_data_reg.final_result <= emit_last;
                        m_data_reg.overflow     <= run_ovf_reg;
                        if (emit_last) begin
                            // Chain is empty after this shift.
                            fill_reg  <= '0;
                            drop_reg  <= 1'b0;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ src/sa_checker.sv @@
// sa_checker: port-level assertions for stable_argsort_unit, bound to it below.
// Depends on sa_pkg and stable_argsort_unit.
`timescale 1ns / 1ps

module sa_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input sa_pkg::in_data_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input sa_pkg::out_data_t m_data
);
    import sa_pkg::*;

    // Stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A final request starts draining; no input is taken meanwhile.
    a_final_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.final_item |=> !s_ready)
        else $error("input accepted right after final request");

    // When input reopens, only the run's final result may newly appear.
    a_no_emit_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && !$past(s_ready) |-> !$rose(m_valid) || m_data.final_result)
        else $error("non-final result after run ended");

endmodule

bind stable_argsort_unit sa_checker u_sa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ test/tb_stable_argsort_unit.sv @@
// tb_stable_argsort_unit: self-checking testbench for the stable argsort unit.
// Depends on sa_pkg and the stable_argsort_unit RTL; reads no files.
`timescale 1ns / 1ps

module tb_stable_argsort_unit;
    import sa_pkg::*;

    localparam int QUIET_LIMIT  = 2000;  // cycles with no request or result moving
    localparam int RANDOM_ITEMS = 130;
    localparam int DRAIN_CYCLES = 20;    // extra wait after all expected results are taken

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_data_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_data_t m_data;

    stable_argsort_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Sort predictor: a private copy of the sorted store. Keys are kept
    // ascending; a new key goes after every stored key <= it, so ties keep
    // arrival order.
    // ------------------------------------------------------------------
    logic [SKEY_W-1:0] rank_key [CAPACITY];
    logic [POS_W-1:0]  rank_pos [CAPACITY];
    int                held_count = 0;
    bit                lost_flag  = 1'b0;
    out_data_t         expected_order [$];

    int runs_seen     = 0;
    int overflow_runs = 0;

    task automatic place_key(input in_data_t req);
        int                slot;
        logic [SKEY_W-1:0] k;
        out_data_t         res;
        k = req.key[SKEY_W-1:0];
        if (held_count < CAPACITY) begin
            slot = held_count;
            while (slot > 0 && rank_key[slot-1] > k) begin
                rank_key[slot] = rank_key[slot-1];
                rank_pos[slot] = rank_pos[slot-1];
                slot--;
            end
            rank_key[slot] = k;
            rank_pos[slot] = POS_W'(held_count);
            held_count++;
        end else begin
            // store full: key is dropped, even when it is the final one
            lost_flag = 1'b1;
        end
        if (req.final_item) begin
            for (int i = 0; i < held_count; i++) begin
                res.position     = rank_pos[i];
                res.final_result = (i == held_count - 1);
                res.overflow     = lost_flag;
                expected_order.push_back(res);
            end
            runs_seen++;
            if (lost_flag)
                overflow_runs++;
            held_count = 0;
            lost_flag  = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    int fail_count   = 0;
    int result_count = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_result(input out_data_t got);
        out_data_t want;
        if (expected_order.size() == 0) begin
            report_mismatch($sformatf("result with none pending (pos %0d last %0b ovf %0b)",
                                      got.position, got.final_result, got.overflow));
        end else begin
            want = expected_order.pop_front();
            if (got.position !== want.position)
                report_mismatch($sformatf("result %0d position %0d, want %0d",
                                          result_count, got.position, want.position));
            if (got.final_result !== want.final_result)
                report_mismatch($sformatf("result %0d final_result %0b, want %0b",
                                          result_count, got.final_result, want.final_result));
            if (got.overflow !== want.overflow)
                report_mismatch($sformatf("result %0d overflow %0b, want %0b",
                                          result_count, got.overflow, want.overflow));
        end
        result_count++;
    endtask

    // ------------------------------------------------------------------
    // Idle lengths: mostly none or short, a few long. A steady phase
    // gives stretches with no idling at all.
    // ------------------------------------------------------------------
    function automatic int pick_idle(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: pops pending requests at the falling edge. Valid is
    // only dropped after acceptance, and only for a gap or with no request pending.
    // ------------------------------------------------------------------
    in_data_t pending_reqs [$];
    int       gap_left  = 0;
    bit       req_taken = 1'b0;  // request accepted at the last rising edge
    int       sent_count = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (gap_left > 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() > 0) begin
                s_data   <= pending_reqs.pop_front();
                s_valid  <= 1'b1;
                gap_left <= pick_idle(((sent_count / 40) % 3) == 1);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result-side backpressure, also changed at the falling edge.
    int stall_left  = 0;
    int cycle_count = 0;

    always @(negedge aclk) begin
        cycle_count++;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_idle(((cycle_count / 50) % 3) == 1);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples both handshakes at the rising edge, feeds accepted
    // requests to the predictor and checks accepted results.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            req_taken    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                place_key(s_data);
                sent_count++;
            end
            if (m_valid && m_ready)
                check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: nothing moving for too long ends the run.
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge aclk);
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("stable_argsort_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int set_count = 0;

    task automatic add_req(input logic [IN_KEY_W-1:0] k, input bit fin);
        in_data_t req;
        req.key        = k;
        req.final_item = fin;
        pending_reqs.push_back(req);
        if (fin)
            set_count++;
    endtask

    // mode 0: any key; 1: tiny pool, lots of ties; 2: extremes and random
    function automatic logic [IN_KEY_W-1:0] draw_key(input int mode);
        case (mode)
            1: return IN_KEY_W'($urandom_range(0, 3));
            2: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return '1;
                    2: return {1'b1, {(IN_KEY_W-1){1'b0}}};
                    3: return {1'b0, {(IN_KEY_W-1){1'b1}}};
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic add_set(input int len, input int mode);
        for (int i = 0; i < len; i++)
            add_req(draw_key(mode), i == len - 1);
    endtask

    initial begin
        int set_no;
        int len;
        int r;
        int random_items;

        // Directed sets
        add_req(32'h0000_0000, 1'b1);            // single-element run
        add_req(32'hFFFF_FFFF, 1'b1);            // single, max key
        add_req(32'hFFFF_FFFF, 1'b0);            // extremes interleaved
        add_req(32'h0000_0000, 1'b0);
        add_req(32'hFFFF_FFFF, 1'b0);
        add_req(32'h0000_0000, 1'b1);
        for (int i = 0; i < 5; i++)              // all keys equal: arrival order
            add_req(32'h0000_0007, i == 4);
        add_req(32'd40, 1'b0);                   // strictly descending
        add_req(32'd30, 1'b0);
        add_req(32'd20, 1'b0);
        add_req(32'd10, 1'b1);
        add_req(32'h7FFF_FFFF, 1'b0);            // sign-bit boundary, unsigned compare
        add_req(32'h8000_0000, 1'b0);
        add_req(32'h7FFF_FFFF, 1'b0);
        add_req(32'h0000_0001, 1'b1);
        add_req(32'hA5A5_5A5A, 1'b0);            // ties mixed with others
        add_req(32'h0000_0003, 1'b0);
        add_req(32'hA5A5_5A5A, 1'b0);
        add_req(32'h0000_0003, 1'b1);

        // Random sets; two forced oversize sets cover the full store, once
        // with only the final key dropped and once with earlier drops too.
        set_no       = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS || set_no <= 2) begin
            r = $urandom_range(0, 99);
            if (set_no == 0)
                len = CAPACITY + 1;
            else if (set_no == 2)
                len = CAPACITY + $urandom_range(2, 4);
            else if (r < 70)
                len = $urandom_range(1, 8);
            else if (r < 95)
                len = $urandom_range(9, 24);
            else
                len = $urandom_range(30, CAPACITY);
            add_set(len, $urandom_range(0, 2));
            random_items += len;
            set_no++;
        end

        // Reset: synchronous, held low from the start, released on a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every request to go in and every result to come out
        while (pending_reqs.size() != 0 || s_valid || expected_order.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (expected_order.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_order.size()));

        $display("Covered %0d requests in %0d sets; %0d sorted positions checked.",
                 sent_count, set_count, result_count);
        $display("Runs with dropped keys: %0d of %0d; mismatches: %0d.",
                 overflow_runs, runs_seen, fail_count);
        if (fail_count == 0)
            $display("stable_argsort_unit verification clean");
        else
            $display("stable_argsort_unit verification failed");
        $finish;
    end

endmodule
